/* design/leb_pkg.sv */
// ----------------------------------------------------------------------------
// leb_pkg
// Shared constants and types for the line edit buffer.
// ----------------------------------------------------------------------------
package leb_pkg;

    localparam int CAPACITY = 4096;
    localparam int ADDR_W   = $clog2(CAPACITY);
    localparam int CNT_W    = $clog2(CAPACITY + 1);

    localparam logic [7:0] KEY_DELETE = 8'h2D;
    localparam logic [7:0] KEY_LEFT   = 8'h3C;
    localparam logic [7:0] KEY_RIGHT  = 8'h3E;
    localparam logic [7:0] KEY_HOME   = 8'h5B;
    localparam logic [7:0] KEY_END    = 8'h5D;

    localparam logic OP_KEY  = 1'b0;
    localparam logic OP_READ = 1'b1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_FETCH,
        S_MOVE,
        S_FINISH
    } state_t;

endpackage

/* design/line_edit_buffer.sv */
// ----------------------------------------------------------------------------
// line_edit_buffer
// Gap buffer line editor with a cursor and positional character reads.
// ----------------------------------------------------------------------------
// Usage: the s_ channel carries one item per handshake: either a keystroke
// (s_operation = 0, s_key) or a read of the character at s_position
// (s_operation = 1). Every item yields exactly one item on the m_ channel
// with the read character (zero for keystrokes or out-of-range reads), the
// text length, the cursor position and the full-drop flag.
// Characters live in one single-port-write, single-port-read memory laid
// out as a gap buffer: text left of the cursor sits at the bottom, text
// right of it at the top. A small sequencer drives the memory ports.
// From acceptance to the offered result, insert, delete, blocked moves and
// out-of-range reads pass through S_EXEC and S_FINISH; an in-range read
// adds S_FETCH; a cursor move adds S_FETCH and S_MOVE for each character
// crossed (one for left or right, all up to the text's start or end for
// home or end), each costing one memory read and one memory write. s_ready
// is high only while the sequencer is idle, so one item is in work at a
// time, and the next item can be taken while a result is offered. A
// finished result waits in the output register while the next item is
// accepted. If the receiver stalls, the sequencer holds in its final state
// until the output register frees. Reset empties the text and homes the
// cursor; the memory itself is not cleared and needs no clearing pass.
// ----------------------------------------------------------------------------
module line_edit_buffer (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_operation,
    input  logic [7:0]  s_key,
    input  logic [11:0] s_position,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [7:0]  m_read_char,
    output logic [12:0] m_text_length,
    output logic [12:0] m_cursor_pos,
    output logic        m_dropped_full
);
    import leb_pkg::*;

    localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);

    state_t            state_reg, state_next;
    logic [CNT_W-1:0]  cursor_reg, cursor_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic              op_reg;
    logic [7:0]        key_reg;
    logic [11:0]       pos_reg;
    logic              hit_reg, hit_next;
    logic              drop_reg, drop_next;
    logic              m_valid_reg, m_valid_next;
    logic [7:0]        m_char_reg, m_char_next;
    logic [12:0]       m_len_reg, m_len_next;
    logic [12:0]       m_cur_reg, m_cur_next;
    logic              m_drop_reg, m_drop_next;

    logic [7:0]        mem [CAPACITY];
    logic [7:0]        rdata_reg;
    logic              rd_en, wr_en;
    logic [ADDR_W-1:0] rd_addr, wr_addr;
    logic [7:0]        wr_data;

    logic [CNT_W-1:0]  right_start;
    logic [CNT_W-1:0]  pos_ext;
    logic [CNT_W-1:0]  read_phys;
    logic              go_left;
    logic              is_move;
    logic              accept;

    // First physical slot of the text to the right of the cursor.
    assign right_start = cursor_reg + (CAP_CNT - count_reg);
    assign pos_ext     = CNT_W'(pos_reg);
    // Logical positions at or past the cursor skip over the gap.
    assign read_phys   = (pos_ext < cursor_reg) ? pos_ext
                                                : pos_ext + (CAP_CNT - count_reg);
    assign go_left     = (key_reg == KEY_LEFT) || (key_reg == KEY_HOME);
    assign is_move     = (key_reg == KEY_LEFT) || (key_reg == KEY_HOME) ||
                         (key_reg == KEY_RIGHT) || (key_reg == KEY_END);
    assign accept      = s_valid && s_ready;

    assign s_ready        = (state_reg == S_IDLE);
    assign m_valid        = m_valid_reg;
    assign m_read_char    = m_char_reg;
    assign m_text_length  = m_len_reg;
    assign m_cursor_pos   = m_cur_reg;
    assign m_dropped_full = m_drop_reg;

    always_comb begin
        state_next   = state_reg;
        cursor_next  = cursor_reg;
        count_next   = count_reg;
        hit_next     = hit_reg;
        drop_next    = drop_reg;
        m_valid_next = m_valid_reg;
        m_char_next  = m_char_reg;
        m_len_next   = m_len_reg;
        m_cur_next   = m_cur_reg;
        m_drop_next  = m_drop_reg;
        rd_en        = 1'b0;
        wr_en        = 1'b0;
        rd_addr      = read_phys[ADDR_W-1:0];
        wr_addr      = cursor_reg[ADDR_W-1:0];
        wr_data      = key_reg;

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    state_next = S_EXEC;
                    hit_next   = 1'b0;
                    drop_next  = 1'b0;
                end
            end
            S_EXEC: begin
                state_next = S_FINISH;
                if (op_reg == OP_READ) begin
                    if (pos_ext < count_reg) begin
                        hit_next   = 1'b1;
                        state_next = S_FETCH;
                    end
                end else if (key_reg == KEY_DELETE) begin
                    if (cursor_reg != '0) begin
                        cursor_next = cursor_reg - 1'b1;
                        count_next  = count_reg - 1'b1;
                    end
                end else if (is_move) begin
                    if (go_left ? (cursor_reg != '0) : (cursor_reg != count_reg)) begin
                        state_next = S_FETCH;
                    end
                end else if (count_reg == CAP_CNT) begin
                    drop_next = 1'b1;
                end else begin
                    wr_en       = 1'b1;
                    cursor_next = cursor_reg + 1'b1;
                    count_next  = count_reg + 1'b1;
                end
            end
            S_FETCH: begin
                rd_en = 1'b1;
                if (op_reg == OP_READ) begin
                    rd_addr    = read_phys[ADDR_W-1:0];
                    state_next = S_FINISH;
                end else begin
                    rd_addr    = go_left ? ADDR_W'(cursor_reg - 1'b1)
                                         : right_start[ADDR_W-1:0];
                    state_next = S_MOVE;
                end
            end
            S_MOVE: begin
                // Carry one character across the gap.
                wr_en      = 1'b1;
                wr_data    = rdata_reg;
                state_next = S_FINISH;
                if (go_left) begin
                    wr_addr     = ADDR_W'(right_start - 1'b1);
                    cursor_next = cursor_reg - 1'b1;
                    if ((key_reg == KEY_HOME) && (cursor_reg != CNT_W'(1))) begin
                        state_next = S_FETCH;
                    end
                end else begin
                    wr_addr     = cursor_reg[ADDR_W-1:0];
                    cursor_next = cursor_reg + 1'b1;
                    if ((key_reg == KEY_END) && (cursor_reg + 1'b1 != count_reg)) begin
                        state_next = S_FETCH;
                    end
                end
            end
            S_FINISH: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next = 1'b1;
                    m_char_next  = hit_reg ? rdata_reg : 8'h00;
                    m_len_next   = 13'(count_reg);
                    m_cur_next   = 13'(cursor_reg);
                    m_drop_next  = drop_reg;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            cursor_reg  <= '0;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            cursor_reg  <= cursor_next;
            count_reg   <= count_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            op_reg  <= s_operation;
            key_reg <= s_key;
            pos_reg <= s_position;
        end
        hit_reg    <= hit_next;
        drop_reg   <= drop_next;
        m_char_reg <= m_char_next;
        m_len_reg  <= m_len_next;
        m_cur_reg  <= m_cur_next;
        m_drop_reg <= m_drop_next;
    end

    // Character memory: one write port, one registered read port.
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rdata_reg <= mem[rd_addr];
        end
    end

`ifndef SYNTH
    a_cursor_in_text: assert property (@(posedge aclk) disable iff (!aresetn)
        cursor_reg <= count_reg)
        else $error("cursor beyond end of text");

    a_count_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CAP_CNT)
        else $error("text length beyond capacity");

    a_move_after_fetch: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == S_MOVE |-> $past(state_reg) == S_FETCH)
        else $error("gap move without a preceding memory read");

    a_drop_only_full: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && m_drop_reg |-> m_len_reg == 13'(CAPACITY))
        else $error("insert dropped while text not full");

    a_no_write_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == S_IDLE |-> !wr_en && !rd_en)
        else $error("memory access while idle");
`endif

endmodule
